// ----- rtl/adll_pkg.sv -----
package adll_pkg;

  // Pool geometry. A slot pointer is one bit wider than a slot index so that
  // the value SLOTS can stand for "no slot".
  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int PTR_W = $clog2(SLOTS + 1);
  localparam logic [PTR_W-1:0] NONE_PTR = PTR_W'(SLOTS);

  // Default number of name characters kept per entry.
  localparam int NAME_CHARS_DEF = 8;

  typedef enum logic [2:0] {
    CMD_ADD_FIRST = 3'd0,
    CMD_ADD_AFTER = 3'd1,
    CMD_ADD_LAST  = 3'd2,
    CMD_DEL_FIRST = 3'd3,
    CMD_DEL_AFTER = 3'd4,
    CMD_DEL_LAST  = 3'd5,
    CMD_READ      = 3'd6,
    CMD_NOP       = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BADSLOT = 2'd3
  } status_e;

  // One command item.
  typedef struct packed {
    logic [2:0]         command;
    logic [3:0]         slot;
    logic signed [31:0] number;
    logic [63:0]        name_bytes;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         slot_touched;
    logic [4:0]         element_count;
    logic [4:0]         head_slot;
    logic [4:0]         tail_slot;
    logic signed [31:0] number_out;
    logic [63:0]        name_out;
    logic [4:0]         next_out;
    logic [4:0]         prev_out;
    logic               slot_in_use;
  } rsp_t;

endpackage

// ----- rtl/adll_cmd_if.sv -----
interface adll_cmd_if import adll_pkg::*; ();

  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ----- rtl/adll_rsp_if.sv -----
interface adll_rsp_if import adll_pkg::*; ();

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ----- rtl/array_doubly_linked_list_unit.sv -----
// Doubly linked list kept in a fixed pool of slots.
// Commands arrive on cmd_i (valid/ready); each one gives exactly one result
// item on rsp_o (valid/ready), in command order. The commands insert at the
// head, after a slot or at the tail, remove the head, the successor of a slot
// or the tail, and read a slot. An insert takes the lowest free slot.
// Payload and links live in one synchronous memory with one read and one
// write port; occupancy, head, tail and the entry count are flip-flops.
// A command is taken in the idle state, then a sequencer steps through a
// state for each dependent memory read or link write, then loads the result
// register; errors and no-ops go straight to the result load. The next
// command is taken in the cycle after the result is loaded, so a command
// holds the unit through its whole chain of link reads and writes through
// the single memory port.
// Reset empties the list at once: all slots free, head and tail none.
// A stalled receiver holds the result register; the following command is
// still accepted and worked on, and it waits only to load its own result.
module array_doubly_linked_list_unit import adll_pkg::*; #(
  parameter int NAME_CHARS = NAME_CHARS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  adll_cmd_if.sink   cmd_i,
  adll_rsp_if.source rsp_o
);

  localparam int NAME_W = 8 * NAME_CHARS;

  typedef struct packed {
    logic signed [31:0] number;
    logic [NAME_W-1:0]  name;
    logic [PTR_W-1:0]   next;
    logic [PTR_W-1:0]   prev;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_INS_SELF,
    S_INS_P,
    S_INS_N,
    S_DA_RD,
    S_DEL_RD,
    S_UNL_P,
    S_UNL_N,
    S_RD_RD,
    S_RESP
  } state_e;

  state_e             state_q, state_d;
  status_e            st_q, st_d;
  logic [PTR_W-1:0]   tgt_q, tgt_d;
  logic [PTR_W-1:0]   prv_q, prv_d;
  logic [PTR_W-1:0]   nxt_q, nxt_d;
  logic signed [31:0] num_q, num_d;
  logic [NAME_W-1:0]  name_q, name_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   tail_q, tail_d;
  logic [PTR_W-1:0]   cnt_q, cnt_d;
  logic [SLOTS-1:0]   used_q, used_d;
  logic               rsp_vld_q, rsp_vld_d;
  rsp_t               rsp_q, rsp_d;

  // Memory port controls.
  entry_t           entry_q [SLOTS];
  entry_t           rd_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_pay, wr_nxt, wr_prv;
  logic [IDX_W-1:0] wr_addr;
  logic [PTR_W-1:0] wr_next, wr_prev;

  logic [PTR_W-1:0] free_ptr;
  logic [PTR_W-1:0] ref_ptr;
  logic             ref_ok, full, empty;
  logic             tgt_have, tgt_live;
  logic             da_ok;

  // Lowest free slot, or none when every slot is taken.
  always_comb begin
    free_ptr = NONE_PTR;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) free_ptr = PTR_W'(i);
    end
  end

  assign ref_ptr = PTR_W'(cmd_i.data.slot);
  assign ref_ok  = (ref_ptr < NONE_PTR) && used_q[cmd_i.data.slot[IDX_W-1:0]];
  assign full    = (cnt_q >= NONE_PTR) || (free_ptr == NONE_PTR);
  assign empty   = (cnt_q == '0) || (head_q == NONE_PTR) || (tail_q == NONE_PTR);

  // The successor read for a remove-after must be a live slot.
  assign da_ok = (rd_q.next < NONE_PTR) && used_q[rd_q.next[IDX_W-1:0]];

  assign tgt_have = (tgt_q != NONE_PTR);
  assign tgt_live = tgt_have && used_q[tgt_q[IDX_W-1:0]];

  // Sequencer: decode, then read, modify and write back the links.
  always_comb begin
    state_d   = state_q;
    st_d      = st_q;
    tgt_d     = tgt_q;
    prv_d     = prv_q;
    nxt_d     = nxt_q;
    num_d     = num_q;
    name_d    = name_q;
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    used_d    = used_q;
    rsp_vld_d = rsp_vld_q && !rsp_o.ready;
    rsp_d     = rsp_q;
    rd_en     = 1'b0;
    rd_addr   = cmd_i.data.slot[IDX_W-1:0];
    wr_pay    = 1'b0;
    wr_nxt    = 1'b0;
    wr_prv    = 1'b0;
    wr_addr   = tgt_q[IDX_W-1:0];
    wr_next   = nxt_q;
    wr_prev   = prv_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          num_d   = cmd_i.data.number;
          name_d  = cmd_i.data.name_bytes[NAME_W-1:0];
          tgt_d   = NONE_PTR;
          st_d    = ST_OK;
          state_d = S_RESP;
          unique case (cmd_e'(cmd_i.data.command))
            CMD_ADD_FIRST, CMD_ADD_LAST: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                tgt_d = free_ptr;
                if (cmd_e'(cmd_i.data.command) == CMD_ADD_FIRST) begin
                  prv_d = NONE_PTR;
                  nxt_d = head_q;
                end else begin
                  prv_d = tail_q;
                  nxt_d = NONE_PTR;
                end
                state_d = S_INS_SELF;
              end
            end
            CMD_ADD_AFTER: begin
              if (!ref_ok) begin
                st_d = ST_BADSLOT;
              end else if (full) begin
                st_d = ST_FULL;
              end else begin
                tgt_d   = free_ptr;
                prv_d   = ref_ptr;
                rd_en   = 1'b1;
                state_d = S_ADD_RD;
              end
            end
            CMD_DEL_FIRST, CMD_DEL_LAST: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else begin
                if (cmd_e'(cmd_i.data.command) == CMD_DEL_FIRST) begin
                  tgt_d   = head_q;
                  rd_addr = head_q[IDX_W-1:0];
                end else begin
                  tgt_d   = tail_q;
                  rd_addr = tail_q[IDX_W-1:0];
                end
                rd_en   = 1'b1;
                state_d = S_DEL_RD;
              end
            end
            CMD_DEL_AFTER: begin
              if (!ref_ok) begin
                st_d = ST_BADSLOT;
              end else begin
                rd_en   = 1'b1;
                state_d = S_DA_RD;
              end
            end
            CMD_READ: begin
              if (!ref_ok) begin
                st_d = ST_BADSLOT;
              end else begin
                tgt_d   = ref_ptr;
                rd_en   = 1'b1;
                state_d = S_RD_RD;
              end
            end
            CMD_NOP: begin
              st_d = ST_OK;
            end
          endcase
        end
      end

      // Insert after: the new entry takes over the reference slot's successor.
      S_ADD_RD: begin
        nxt_d   = rd_q.next;
        state_d = S_INS_SELF;
      end

      // Write the new entry and update occupancy, head and tail.
      S_INS_SELF: begin
        wr_pay = 1'b1;
        wr_nxt = 1'b1;
        wr_prv = 1'b1;
        used_d[tgt_q[IDX_W-1:0]] = 1'b1;
        cnt_d = cnt_q + PTR_W'(1);
        if (prv_q == NONE_PTR) head_d = tgt_q;
        if (nxt_q == NONE_PTR) tail_d = tgt_q;
        if (prv_q != NONE_PTR) begin
          state_d = S_INS_P;
        end else if (nxt_q != NONE_PTR) begin
          state_d = S_INS_N;
        end else begin
          state_d = S_RESP;
        end
      end

      S_INS_P: begin
        wr_nxt  = 1'b1;
        wr_addr = prv_q[IDX_W-1:0];
        wr_next = tgt_q;
        state_d = (nxt_q != NONE_PTR) ? S_INS_N : S_RESP;
      end

      S_INS_N: begin
        wr_prv  = 1'b1;
        wr_addr = nxt_q[IDX_W-1:0];
        wr_prev = tgt_q;
        state_d = S_RESP;
      end

      // Remove after: the victim is the reference slot's successor.
      S_DA_RD: begin
        if (!da_ok) begin
          st_d    = ST_EMPTY;
          tgt_d   = NONE_PTR;
          state_d = S_RESP;
        end else begin
          tgt_d   = rd_q.next;
          rd_en   = 1'b1;
          rd_addr = rd_q.next[IDX_W-1:0];
          state_d = S_DEL_RD;
        end
      end

      // The victim's links are known: free it and fix head and tail.
      S_DEL_RD: begin
        prv_d  = rd_q.prev;
        nxt_d  = rd_q.next;
        num_d  = rd_q.number;
        name_d = rd_q.name;
        used_d[tgt_q[IDX_W-1:0]] = 1'b0;
        cnt_d = cnt_q - PTR_W'(1);
        if (rd_q.prev == NONE_PTR) head_d = rd_q.next;
        if (rd_q.next == NONE_PTR) tail_d = rd_q.prev;
        if (rd_q.prev != NONE_PTR) begin
          state_d = S_UNL_P;
        end else if (rd_q.next != NONE_PTR) begin
          state_d = S_UNL_N;
        end else begin
          state_d = S_RESP;
        end
      end

      S_UNL_P: begin
        wr_nxt  = 1'b1;
        wr_addr = prv_q[IDX_W-1:0];
        wr_next = nxt_q;
        state_d = (nxt_q != NONE_PTR) ? S_UNL_N : S_RESP;
      end

      S_UNL_N: begin
        wr_prv  = 1'b1;
        wr_addr = nxt_q[IDX_W-1:0];
        wr_prev = prv_q;
        state_d = S_RESP;
      end

      S_RD_RD: begin
        prv_d   = rd_q.prev;
        nxt_d   = rd_q.next;
        num_d   = rd_q.number;
        name_d  = rd_q.name;
        state_d = S_RESP;
      end

      // Load the result register once it is free.
      S_RESP: begin
        if (!rsp_vld_q || rsp_o.ready) begin
          rsp_vld_d           = 1'b1;
          rsp_d.status        = st_q;
          rsp_d.slot_touched  = tgt_q;
          rsp_d.element_count = cnt_q;
          rsp_d.head_slot     = head_q;
          rsp_d.tail_slot     = tail_q;
          rsp_d.number_out    = tgt_have ? num_q : 32'sd0;
          rsp_d.name_out      = tgt_have ? 64'(name_q) : 64'd0;
          rsp_d.next_out      = tgt_live ? nxt_q : NONE_PTR;
          rsp_d.prev_out      = tgt_live ? prv_q : NONE_PTR;
          rsp_d.slot_in_use   = tgt_live;
          state_d             = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      st_q      <= ST_OK;
      tgt_q     <= NONE_PTR;
      prv_q     <= NONE_PTR;
      nxt_q     <= NONE_PTR;
      num_q     <= '0;
      name_q    <= '0;
      head_q    <= NONE_PTR;
      tail_q    <= NONE_PTR;
      cnt_q     <= '0;
      used_q    <= '0;
      rsp_vld_q <= 1'b0;
      rsp_q     <= '0;
    end else begin
      state_q   <= state_d;
      st_q      <= st_d;
      tgt_q     <= tgt_d;
      prv_q     <= prv_d;
      nxt_q     <= nxt_d;
      num_q     <= num_d;
      name_q    <= name_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      cnt_q     <= cnt_d;
      used_q    <= used_d;
      rsp_vld_q <= rsp_vld_d;
      rsp_q     <= rsp_d;
    end
  end

  // Entry memory: lane-enabled write, registered read.
  always_ff @(posedge clk_i) begin
    if (wr_pay) begin
      entry_q[wr_addr].number <= num_q;
      entry_q[wr_addr].name   <= name_q;
    end
    if (wr_nxt) entry_q[wr_addr].next <= wr_next;
    if (wr_prv) entry_q[wr_addr].prev <= wr_prev;
    if (rd_en) rd_q <= entry_q[rd_addr];
  end

  assign cmd_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

`ifndef SYNTHESIS
  // The count always matches the number of occupied slots.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == PTR_W'($countones(used_q)))
    else $error("entry count differs from occupied slots");

  // Head and tail are none exactly when the list is empty.
  a_ends_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cnt_q == '0) == (head_q == NONE_PTR)) && ((cnt_q == '0) == (tail_q == NONE_PTR)))
    else $error("head or tail inconsistent with entry count");

  // The sequencer never reads and writes the memory in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && (wr_pay || wr_nxt || wr_prv)))
    else $error("memory read overlaps a write");
`endif

endmodule
